/* design/rme_pkg.sv */
package rme_pkg;

   localparam int DATA_W     = 64;
   localparam int CMD_W      = 4;
   localparam int REG_SEL_W  = 3;
   localparam int TARGET_W   = 10;
   localparam int NEXT_PC_W  = 10;
   localparam int STATUS_W   = 3;
   localparam int LEN_W      = 11;
   // program length is 11 bits, so a valid pc never exceeds 11 bits
   localparam int PC_W       = LEN_W;
   localparam int COST_W     = 7;

   localparam int DEF_NUM_REGS   = 5;
   localparam int DEF_MEM_DEPTH  = 1024;
   localparam int DEF_PROG_DEPTH = 1024;

   localparam logic [LEN_W-1:0]  LEN_RESET   = 11'd1024;
   localparam logic [COST_W-1:0] COST_IO     = 7'd100;
   localparam logic [COST_W-1:0] COST_MEM    = 7'd10;
   localparam logic [COST_W-1:0] COST_SIMPLE = 7'd1;

   typedef enum logic [CMD_W-1:0] {
      OP_GET   = 4'd0,
      OP_PUT   = 4'd1,
      OP_LOAD  = 4'd2,
      OP_STORE = 4'd3,
      OP_COPY  = 4'd4,
      OP_ADD   = 4'd5,
      OP_SUB   = 4'd6,
      OP_SHR   = 4'd7,
      OP_SHL   = 4'd8,
      OP_INC   = 4'd9,
      OP_DEC   = 4'd10,
      OP_ZERO  = 4'd11,
      OP_JUMP  = 4'd12,
      OP_JZERO = 4'd13,
      OP_JODD  = 4'd14,
      OP_HALT  = 4'd15
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_HALTED   = 3'd1,
      ST_BAD_PC   = 3'd2,
      ST_BAD_ADDR = 3'd3,
      ST_BAD_REG  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_ISSUE,
      BK_FINISH
   } back_state_type;

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [REG_SEL_W-1:0] reg_index;
      logic [TARGET_W-1:0]  jump_target;
      logic [DATA_W-1:0]    get_value;
   } req_type;

   typedef struct packed {
      logic [NEXT_PC_W-1:0] next_pc;
      logic [STATUS_W-1:0]  status;
      logic                 put_valid;
      logic [DATA_W-1:0]    put_value;
      logic [DATA_W-1:0]    cost_total;
   } rsp_type;

   typedef struct packed {
      op_type               cmd;
      logic [REG_SEL_W-1:0] ri;
      logic [TARGET_W-1:0]  target;
      logic [DATA_W-1:0]    gv;
      logic                 bad_reg;
      logic                 uses_mem;
      logic [COST_W-1:0]    cost;
   } decoded_type;

endpackage

/* design/rme_ram.sv */
module rme_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rme_fifo.sv */
module rme_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/rme_front.sv */
module rme_front
   import rme_pkg::*;
#(
   parameter int NUM_REGS = DEF_NUM_REGS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  req_type     req_data,
   output logic        req_full,
   input  logic        clearing,
   input  logic        dec_pop,
   output decoded_type dec_data,
   output logic        dec_empty
);

   decoded_type dec_word;
   op_type      op;
   logic        q_full;
   logic        accept;

   assign op       = op_type'(req_data.cmd);
   assign req_full = q_full || clearing;
   assign accept   = req_push && !req_full;

   always_comb begin
      dec_word.cmd      = op;
      dec_word.ri       = req_data.reg_index;
      dec_word.target   = req_data.jump_target;
      dec_word.gv       = req_data.get_value;
      // jump ignores the register operand
      dec_word.bad_reg  = (op != OP_JUMP) && (32'(req_data.reg_index) >= NUM_REGS);
      dec_word.uses_mem = op inside {OP_LOAD, OP_STORE, OP_ADD, OP_SUB};
      case (op)
         OP_GET, OP_PUT:                  dec_word.cost = COST_IO;
         OP_LOAD, OP_STORE, OP_ADD, OP_SUB: dec_word.cost = COST_MEM;
         default:                         dec_word.cost = COST_SIMPLE;
      endcase
   end

   rme_fifo #(
      .WIDTH ($bits(decoded_type))
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (dec_word),
      .full      (q_full),
      .pop       (dec_pop),
      .pop_data  (dec_data),
      .empty     (dec_empty)
   );

endmodule

/* design/rme_back.sv */
module rme_back
   import rme_pkg::*;
#(
   parameter int NUM_REGS   = DEF_NUM_REGS,
   parameter int MEM_DEPTH  = DEF_MEM_DEPTH,
   parameter int PROG_DEPTH = DEF_PROG_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [LEN_W-1:0]  csr_wr_data,
   input  decoded_type       dec_data,
   input  logic              dec_empty,
   output logic              dec_pop,
   output logic              clearing,
   input  logic              res_full,
   output logic              res_push,
   output rsp_type           res_data
);

   localparam int RI_W   = $clog2(NUM_REGS);
   localparam int ADDR_W = $clog2(MEM_DEPTH);

   back_state_type state_ff, state_in;

   logic [DATA_W-1:0] regs_ff [NUM_REGS];
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [DATA_W-1:0] cost_ff, cost_in;
   logic              halted_ff, halted_in;
   logic [LEN_W-1:0]  prog_len_ff;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   decoded_type       cur_ff;

   logic              finish;
   logic              rd_en;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [DATA_W-1:0] mv;

   logic [RI_W-1:0]   ri_sel;
   logic [RI_W-1:0]   wr_idx;
   logic [DATA_W-1:0] rv;
   logic [DATA_W-1:0] reg_val;
   logic              reg_wr;
   logic              taken;
   logic [PC_W:0]     npc;
   int unsigned       limit;
   status_type        status;
   logic              exec;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_ff == ADDR_W'(MEM_DEPTH - 1)) state_in = BK_ISSUE;
         end
         BK_ISSUE: begin
            if (!dec_empty && !res_full) state_in = BK_FINISH;
         end
         BK_FINISH: state_in = BK_ISSUE;
         default:   state_in = BK_CLEAR;
      endcase
   end

   // sequencer outputs
   always_comb begin
      clearing = 1'b0;
      dec_pop  = 1'b0;
      rd_en    = 1'b0;
      finish   = 1'b0;
      case (state_ff)
         BK_CLEAR:  clearing = 1'b1;
         BK_ISSUE: begin
            dec_pop = !dec_empty && !res_full;
            rd_en   = !dec_empty && !res_full;
         end
         BK_FINISH: finish = 1'b1;
         default:   clearing = 1'b0;
      endcase
   end

   // execute
   always_comb begin
      ri_sel  = (cur_ff.cmd == OP_JUMP) ? '0 : cur_ff.ri[RI_W-1:0];
      rv      = regs_ff[ri_sel];
      taken   = (cur_ff.cmd == OP_JUMP) || (cur_ff.cmd == OP_JZERO && rv == '0) ||
                (cur_ff.cmd == OP_JODD && rv[0]);
      npc     = taken ? (PC_W+1)'(cur_ff.target) : {1'b0, pc_ff} + (PC_W+1)'(1);
      limit   = (32'(prog_len_ff) < PROG_DEPTH) ? 32'(prog_len_ff) : PROG_DEPTH;

      exec = 1'b0;
      if (halted_ff || cur_ff.cmd == OP_HALT) begin
         status = ST_HALTED;
      end else if (cur_ff.bad_reg) begin
         status = ST_BAD_REG;
      end else if (cur_ff.uses_mem && regs_ff[0] >= 64'(MEM_DEPTH)) begin
         status = ST_BAD_ADDR;
      end else if (32'(npc) >= limit) begin
         status = ST_BAD_PC;
      end else begin
         status = ST_OK;
         exec   = 1'b1;
      end

      wr_idx  = ri_sel;
      reg_wr  = 1'b1;
      case (cur_ff.cmd)
         OP_GET:  reg_val = cur_ff.gv;
         OP_LOAD: reg_val = mv;
         OP_ADD:  reg_val = rv + mv;
         OP_SUB:  reg_val = (rv >= mv) ? rv - mv : '0;
         OP_COPY: begin
            reg_val = rv;
            wr_idx  = '0;
         end
         OP_SHR:  reg_val = rv >> 1;
         OP_SHL:  reg_val = rv << 1;
         OP_INC:  reg_val = rv + DATA_W'(1);
         OP_DEC:  reg_val = (rv != '0) ? rv - DATA_W'(1) : '0;
         OP_ZERO: reg_val = '0;
         default: begin
            reg_val = '0;
            reg_wr  = 1'b0;
         end
      endcase

      pc_in     = (finish && exec) ? npc[PC_W-1:0] : pc_ff;
      cost_in   = (finish && exec) ? cost_ff + DATA_W'(cur_ff.cost) : cost_ff;
      halted_in = halted_ff || (finish && cur_ff.cmd == OP_HALT);
      clr_in    = clearing ? clr_ff + ADDR_W'(1) : clr_ff;

      wr_en   = clearing || (finish && exec && cur_ff.cmd == OP_STORE);
      wr_addr = clearing ? clr_ff : regs_ff[0][ADDR_W-1:0];
      wr_data = clearing ? '0 : rv;

      res_push            = finish;
      res_data.next_pc    = pc_in[NEXT_PC_W-1:0];
      res_data.status     = status;
      res_data.put_valid  = exec && cur_ff.cmd == OP_PUT;
      res_data.put_value  = (exec && cur_ff.cmd == OP_PUT) ? rv : '0;
      res_data.cost_total = cost_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_CLEAR;
         pc_ff       <= '0;
         cost_ff     <= '0;
         halted_ff   <= 1'b0;
         prog_len_ff <= LEN_RESET;
         clr_ff      <= '0;
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         pc_ff     <= pc_in;
         cost_ff   <= cost_in;
         halted_ff <= halted_in;
         clr_ff    <= clr_in;
         if (csr_wr_en) begin
            prog_len_ff <= csr_wr_data;
         end
         if (finish && exec && reg_wr) begin
            regs_ff[wr_idx] <= reg_val;
         end
      end
   end

   // hold the word under execution
   always_ff @(posedge clock) begin
      if (dec_pop) begin
         cur_ff <= dec_data;
      end
   end

   rme_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MEM_DEPTH)
   ) u_data_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (regs_ff[0][ADDR_W-1:0]),
      .rd_data (mv)
   );

endmodule

/* design/register_machine_executor.sv */
// Register machine executor: one decoded instruction per request word.
// Request channel: drive req_data and raise req_push; the word is taken on a
// clock edge where req_full is low. Response channel: while rsp_empty is low
// the oldest result sits on rsp_data; raise rsp_pop to take it.
// csr_wr_en writes csr_wr_data into the program length register at once;
// write it only while no instruction is outstanding.
// A result passes through the request queue, the back end's issue and finish
// states and the output queue. The back end takes a new instruction only once
// the last has finished, set by its read-then-write of the memory at register 0.
// A two-entry queue decouples decode from execution, so requests are taken
// while an earlier instruction is still running.
// Reset clears the registers, pc, cost and halted flag, then sweeps the data
// memory to zero, one word a cycle over its MEM_DEPTH words (1024 by default);
// req_full stays high during the sweep. csr writes are taken throughout.
// When the receiver stalls, results collect in a two-entry output queue,
// execution then waits and the request queue fills until req_full rises.
module register_machine_executor
   import rme_pkg::*;
#(
   parameter int NUM_REGS   = DEF_NUM_REGS,
   parameter int MEM_DEPTH  = DEF_MEM_DEPTH,
   parameter int PROG_DEPTH = DEF_PROG_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  req_type          req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data
);

   decoded_type dec_data;
   logic        dec_empty;
   logic        dec_pop;
   logic        clearing;
   logic        res_full;
   logic        res_push;
   rsp_type     res_data;

   rme_front #(
      .NUM_REGS (NUM_REGS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .clearing  (clearing),
      .dec_pop   (dec_pop),
      .dec_data  (dec_data),
      .dec_empty (dec_empty)
   );

   rme_back #(
      .NUM_REGS   (NUM_REGS),
      .MEM_DEPTH  (MEM_DEPTH),
      .PROG_DEPTH (PROG_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .dec_data    (dec_data),
      .dec_empty   (dec_empty),
      .dec_pop     (dec_pop),
      .clearing    (clearing),
      .res_full    (res_full),
      .res_push    (res_push),
      .res_data    (res_data)
   );

   rme_fifo #(
      .WIDTH ($bits(rsp_type))
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule
